// File: rtl/core/signature_length_deframer_assert.svh
// Assertion macros for the signature length deframer.
`ifndef SIGNATURE_LENGTH_DEFRAMER_ASSERT_SVH
`define SIGNATURE_LENGTH_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define SLD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sld assertion failed");
`define SLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sld assertion failed");
`else
`define SLD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SLD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/sld_pkg.sv
// Shared constants, types and helpers of the signature length deframer.
package sld_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned MaxSigBytes = 8;
  localparam int unsigned MaxLenBytes = 8;
  localparam int unsigned WindowW     = MaxSigBytes * ByteW;
  localparam int unsigned MsgLenW     = MaxLenBytes * ByteW;
  localparam int unsigned SigRegW     = 64;
  localparam int unsigned CountW      = 4;
  localparam int unsigned PhaseW      = 2;
  localparam int unsigned AddrW       = 5;
  localparam int unsigned DataW       = 64;
  localparam int unsigned RegIdxW     = 2;

  localparam logic [CountW-1:0] MaxSigCount = CountW'(MaxSigBytes);
  localparam logic [CountW-1:0] MaxLenCount = CountW'(MaxLenBytes);
  localparam logic [CountW-1:0] FillMax     = {CountW{1'b1}};

  localparam logic [PhaseW-1:0] PhaseSearch  = 2'd0;
  localparam logic [PhaseW-1:0] PhaseLength  = 2'd1;
  localparam logic [PhaseW-1:0] PhasePayload = 2'd2;

  localparam logic [RegIdxW-1:0] RegSignature = 2'd0;
  localparam logic [RegIdxW-1:0] RegSigLength = 2'd1;
  localparam logic [RegIdxW-1:0] RegLenBytes  = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             payload_last;
  } sld_result_t;

  // A count of zero means one; anything above the bound means the bound.
  function automatic logic [CountW-1:0] clamp_count(logic [CountW-1:0] v,
                                                    logic [CountW-1:0] hi);
    logic [CountW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CountW'(1);
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/sld_out_buf.sv
// Two-entry output buffer that holds result words for the downstream side.
module sld_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 res_valid_i,
  input  sld_pkg::sld_result_t res_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  output sld_pkg::sld_result_t out_o,
  input  logic                 out_stall_i
);

  logic                 main_valid_q, main_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  sld_pkg::sld_result_t main_q, main_d;
  sld_pkg::sld_result_t skid_q, skid_d;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        // The input is stalled while the skid entry is full.
        main_d       = skid_q;
        main_valid_d = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        main_d       = res_i;
        main_valid_d = res_valid_i;
      end
    end else if (res_valid_i) begin
      skid_d       = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_o       = main_q;

endmodule

// File: rtl/core/signature_length_deframer.sv
// Top level of the signature length deframer with its register port.
// The deframer takes one byte per clock while in_stall_o is low and returns each payload word
// through the main or skid register of the output buffer. All per-byte work (window shift and
// signature compare, length field shift, payload down-count) is done combinationally ahead of
// the phase registers, so the sustained rate is one byte per cycle while in_stall_o is low.
// Results go through a two-entry output buffer; in_stall_o rises only when both entries are
// held by a stalled output, and reads and writes of the registers take effect at once.
`include "signature_length_deframer_assert.svh"

module signature_length_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sld_pkg::ByteW-1:0]   rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sld_pkg::ByteW-1:0]   payload_byte_o,
  output logic                        payload_last_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sld_pkg::AddrW-1:0]   paddr,
  input  logic [sld_pkg::DataW-1:0]   pwdata,
  output logic [sld_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  logic [sld_pkg::SigRegW-1:0] sig_q;
  logic [sld_pkg::CountW-1:0]  sig_len_q;
  logic [sld_pkg::CountW-1:0]  len_bytes_q;
  logic [sld_pkg::RegIdxW-1:0] reg_idx;
  logic                        cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[sld_pkg::AddrW-1:sld_pkg::AddrW-sld_pkg::RegIdxW];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q       <= '0;
      sig_len_q   <= sld_pkg::CountW'(1);
      len_bytes_q <= sld_pkg::CountW'(1);
    end else if (cfg_write) begin
      case (reg_idx)
        sld_pkg::RegSignature: sig_q       <= pwdata[sld_pkg::SigRegW-1:0];
        sld_pkg::RegSigLength: sig_len_q   <= pwdata[sld_pkg::CountW-1:0];
        sld_pkg::RegLenBytes:  len_bytes_q <= pwdata[sld_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sld_pkg::RegSignature: prdata = sld_pkg::DataW'(sig_q);
      sld_pkg::RegSigLength: prdata = sld_pkg::DataW'(sig_len_q);
      sld_pkg::RegLenBytes:  prdata = sld_pkg::DataW'(len_bytes_q);
      default:               prdata = '0;
    endcase
  end

  // Deframing state.
  logic [sld_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [sld_pkg::WindowW-1:0] window_q, window_d;
  logic [sld_pkg::CountW-1:0]  fill_q, fill_d;
  // Holds the gathered length, then counts down the payload bytes still to come.
  logic [sld_pkg::MsgLenW-1:0] msg_len_q, msg_len_d;

  logic                        accept;
  logic [sld_pkg::CountW-1:0]  sig_n, len_n, fill_inc;
  logic [sld_pkg::WindowW-1:0] window_shift;
  logic [sld_pkg::MsgLenW-1:0] msg_shift;
  logic [sld_pkg::MaxSigBytes-1:0] byte_ok;
  logic                        sig_match;
  logic                        res_valid;
  sld_pkg::sld_result_t        res;
  sld_pkg::sld_result_t        out_word;
  logic                        buf_full;

  assign accept       = in_valid_i && !in_stall_o;
  assign sig_n        = sld_pkg::clamp_count(sig_len_q, sld_pkg::MaxSigCount);
  assign len_n        = sld_pkg::clamp_count(len_bytes_q, sld_pkg::MaxLenCount);
  assign fill_inc     = (fill_q == sld_pkg::FillMax) ? fill_q
                                                     : fill_q + sld_pkg::CountW'(1);
  assign window_shift = (window_q << sld_pkg::ByteW) | sld_pkg::WindowW'(rx_byte_i);
  assign msg_shift    = (msg_len_q << sld_pkg::ByteW) | sld_pkg::MsgLenW'(rx_byte_i);

  always_comb begin
    for (int i = 0; i < sld_pkg::MaxSigBytes; i++) begin
      byte_ok[i] = (sld_pkg::CountW'(i) >= sig_n) ||
                   (window_shift[i*sld_pkg::ByteW +: sld_pkg::ByteW] ==
                    sig_q[i*sld_pkg::ByteW +: sld_pkg::ByteW]);
    end
  end

  assign sig_match = &byte_ok;

  always_comb begin
    phase_d              = phase_q;
    window_d             = window_q;
    fill_d               = fill_q;
    msg_len_d            = msg_len_q;
    res_valid            = 1'b0;
    res.payload_byte     = rx_byte_i;
    res.payload_last     = (msg_len_q == sld_pkg::MsgLenW'(1));
    if (accept) begin
      case (phase_q)
        sld_pkg::PhaseSearch: begin
          window_d = window_shift;
          fill_d   = fill_inc;
          if (fill_inc >= sig_n && sig_match) begin
            phase_d   = sld_pkg::PhaseLength;
            window_d  = '0;
            fill_d    = '0;
            msg_len_d = '0;
          end
        end
        sld_pkg::PhaseLength: begin
          msg_len_d = msg_shift;
          fill_d    = fill_inc;
          if (fill_inc >= len_n) begin
            fill_d = '0;
            if (msg_shift == '0) begin
              phase_d  = sld_pkg::PhaseSearch;
              window_d = '0;
            end else begin
              phase_d = sld_pkg::PhasePayload;
            end
          end
        end
        sld_pkg::PhasePayload: begin
          res_valid = 1'b1;
          msg_len_d = msg_len_q - sld_pkg::MsgLenW'(1);
          if (res.payload_last) begin
            phase_d  = sld_pkg::PhaseSearch;
            window_d = '0;
            fill_d   = '0;
          end
        end
        default: begin
          phase_d  = sld_pkg::PhaseSearch;
          window_d = '0;
          fill_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= sld_pkg::PhaseSearch;
      window_q  <= '0;
      fill_q    <= '0;
      msg_len_q <= '0;
    end else begin
      phase_q   <= phase_d;
      window_q  <= window_d;
      fill_q    <= fill_d;
      msg_len_q <= msg_len_d;
    end
  end

  sld_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_o       (out_word),
    .out_stall_i (out_stall_i)
  );

  assign in_stall_o     = buf_full;
  assign payload_byte_o = out_word.payload_byte;
  assign payload_last_o = out_word.payload_last;

  `SLD_ASSERT_IMPLY(a_res_only_in_payload, clk_i, rst_ni, res_valid, phase_q == sld_pkg::PhasePayload)
  `SLD_ASSERT_IMPLY(a_payload_len_nonzero, clk_i, rst_ni, phase_q == sld_pkg::PhasePayload, msg_len_q != '0)
  `SLD_ASSERT_NEXT(a_last_ends_frame, clk_i, rst_ni, res_valid && res.payload_last, phase_q == sld_pkg::PhaseSearch && fill_q == '0 && window_q == '0)
  `SLD_ASSERT_IMPLY(a_stall_needs_output, clk_i, rst_ni, in_stall_o, out_valid_o)

endmodule

// File: test/signature_length_deframer_checker.sv
// Checker for the signature length deframer: tracks the deframing state and compares payload words.
`timescale 1ns / 1ps

module signature_length_deframer_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [sld_pkg::ByteW-1:0] rx_byte_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [sld_pkg::ByteW-1:0] payload_byte_i,
  input  logic                      payload_last_i,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic                      pready_i,
  input  logic [sld_pkg::AddrW-1:0] paddr_i,
  input  logic [sld_pkg::DataW-1:0] pwdata_i,
  output int                        err_count_o,
  output int                        pending_o,
  output int                        words_out_o
);

  // Register copies.
  logic [63:0] sig_q;
  logic [3:0]  sig_len_q;
  logic [3:0]  len_bytes_q;

  // Deframing state.
  logic [1:0]  phase_q;
  logic [63:0] window_q;
  logic [3:0]  fill_q;
  logic [63:0] msg_len_q;
  logic [63:0] pay_cnt_q;

  sld_pkg::sld_result_t payload_words_q[$];

  function automatic logic [3:0] bounded_count(input logic [3:0] v, input logic [3:0] hi);
    if (v == 4'd0) begin
      return 4'd1;
    end
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [63:0] low_bytes_mask(input logic [3:0] n);
    if (n >= 4'd8) begin
      return '1;
    end
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  task automatic restart_search();
    phase_q  = sld_pkg::PhaseSearch;
    window_q = '0;
    fill_q   = '0;
  endtask

  task automatic bump_fill();
    if (fill_q != 4'hF) begin
      fill_q = fill_q + 4'd1;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [3:0]           n;
    logic [63:0]          m;
    sld_pkg::sld_result_t word;
    case (phase_q)
      sld_pkg::PhaseSearch: begin
        n        = bounded_count(sig_len_q, sld_pkg::MaxSigCount);
        m        = low_bytes_mask(n);
        window_q = {window_q[55:0], b};
        bump_fill();
        if (fill_q >= n && (window_q & m) == (sig_q & m)) begin
          phase_q   = sld_pkg::PhaseLength;
          window_q  = '0;
          fill_q    = '0;
          msg_len_q = '0;
        end
      end
      sld_pkg::PhaseLength: begin
        n         = bounded_count(len_bytes_q, sld_pkg::MaxLenCount);
        msg_len_q = {msg_len_q[55:0], b};
        bump_fill();
        if (fill_q >= n) begin
          if (msg_len_q == '0) begin
            restart_search();
          end else begin
            phase_q   = sld_pkg::PhasePayload;
            fill_q    = '0;
            pay_cnt_q = '0;
          end
        end
      end
      sld_pkg::PhasePayload: begin
        pay_cnt_q         = pay_cnt_q + 64'd1;
        word.payload_byte = b;
        word.payload_last = (pay_cnt_q >= msg_len_q);
        payload_words_q   = {payload_words_q, word};
        if (word.payload_last) begin
          restart_search();
        end
      end
      default: begin
        restart_search();
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    sld_pkg::sld_result_t want;
    if (!rst_ni) begin
      sig_q       = '0;
      sig_len_q   = 4'd1;
      len_bytes_q = 4'd1;
      restart_search();
      msg_len_q   = '0;
      pay_cnt_q   = '0;
      payload_words_q.delete();
      err_count_o = 0;
      words_out_o = 0;
      pending_o   = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[sld_pkg::AddrW-1:3])
          sld_pkg::RegSignature: sig_q       = pwdata_i;
          sld_pkg::RegSigLength: sig_len_q   = pwdata_i[3:0];
          sld_pkg::RegLenBytes:  len_bytes_q = pwdata_i[3:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        deframe_byte(rx_byte_i);
      end
      if (out_valid_i && !out_stall_i) begin
        words_out_o++;
        if (payload_words_q.size() == 0) begin
          err_count_o++;
          $display("%0t: payload word %h last %b arrived with none expected",
                   $time, payload_byte_i, payload_last_i);
        end else begin
          want = payload_words_q.pop_front();
          if (want.payload_byte !== payload_byte_i) begin
            err_count_o++;
            $display("%0t: payload_byte expected %h, got %h",
                     $time, want.payload_byte, payload_byte_i);
          end
          if (want.payload_last !== payload_last_i) begin
            err_count_o++;
            $display("%0t: payload_last expected %b, got %b",
                     $time, want.payload_last, payload_last_i);
          end
        end
      end
      pending_o = payload_words_q.size();
    end
  end

endmodule

// File: test/signature_length_deframer_tb.sv
// Testbench top for the signature length deframer: stimulus, idling, register setup and verdict.
`timescale 1ns / 1ps

module signature_length_deframer_tb;

  localparam int LimitCycles = 200000;
  localparam int LongHold    = 120;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [sld_pkg::ByteW-1:0] rx_byte;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [sld_pkg::ByteW-1:0] payload_byte;
  logic                      payload_last;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [sld_pkg::AddrW-1:0] paddr;
  logic [sld_pkg::DataW-1:0] pwdata;
  logic [sld_pkg::DataW-1:0] prdata;
  logic                      pready;

  int         err_count;
  int         pending;
  int         words_out;
  int         bytes_in  = 0;
  int         settings  = 0;
  int         cycles    = 0;
  idle_mode_e idle_mode = IDLE_NONE;
  logic       hold_go   = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;

  // Stimulus view of the current setting.
  logic [63:0] cur_sig;
  int          cur_n;
  int          cur_len_bytes;

  always #5 clk = ~clk;

  signature_length_deframer u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .payload_byte_o (payload_byte),
    .payload_last_o (payload_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  signature_length_deframer_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .payload_byte_i (payload_byte),
    .payload_last_i (payload_last),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .pready_i       (pready),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .err_count_o    (err_count),
    .pending_o      (pending),
    .words_out_o    (words_out)
  );

  function automatic int send_gap_pct(input idle_mode_e m);
    return (m == IDLE_SEND) ? 45 : (m == IDLE_BOTH) ? 25 : 0;
  endfunction

  function automatic int stall_pct(input idle_mode_e m);
    return (m == IDLE_RECV) ? 45 : (m == IDLE_BOTH) ? 25 : 0;
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    return (v < 1) ? 1 : (v > hi) ? hi : v;
  endfunction

  // A byte equal to no signature byte in use can never be part of a match.
  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    bit         clash;
    do begin
      b     = 8'($urandom_range(0, 255));
      clash = 1'b0;
      for (int i = 0; i < cur_n; i++) begin
        if (cur_sig[8*i +: 8] == b) clash = 1'b1;
      end
    end while (clash);
    return b;
  endfunction

  // Receiver: random stalls per phase, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct(idle_mode));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LimitCycles) begin
      $display("%0t: timeout with %0d words still expected", $time, pending);
      $display("signature_length_deframer_tb: errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct(idle_mode)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_in++;
  endtask

  // Lets every expected word drain and the block go quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sld_pkg::RegIdxW-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input logic [63:0] sig, input int slen, input int lbytes);
    settle();
    write_reg(sld_pkg::RegSignature, sig);
    write_reg(sld_pkg::RegSigLength, 64'(slen));
    write_reg(sld_pkg::RegLenBytes, 64'(lbytes));
    cur_sig       = sig;
    cur_n         = clamp_to(slen & 15, 8);
    cur_len_bytes = clamp_to(lbytes & 15, 8);
    settings++;
  endtask

  // The first signature byte sent is the highest one in use.
  task automatic send_sig_prefix(input int k);
    for (int i = cur_n - 1; i >= cur_n - k; i--) send_byte(cur_sig[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [63:0] len);
    send_sig_prefix(cur_n);
    for (int i = cur_len_bytes - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    for (longint i = 0; i < longint'(len); i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input logic [63:0] sig, input int slen, input int lbytes,
                           input idle_mode_e mode, input int target, input bit with_hold);
    int          count;
    int          r;
    logic [63:0] len;
    count = 0;
    apply_setting(sig, slen, lbytes);
    idle_mode <= mode;
    while (count < target) begin
      repeat ($urandom_range(0, 3)) send_byte(noise_byte());
      if (cur_n > 1 && $urandom_range(0, 99) < 15) begin
        // Broken signature: a prefix cut off by a byte that matches nothing.
        send_sig_prefix($urandom_range(1, cur_n - 1));
        send_byte(noise_byte());
        continue;
      end
      r = $urandom_range(0, 99);
      if (r < 8) len = 0;
      else if (r < 93) len = $urandom_range(1, 16);
      else if (r < 98) len = $urandom_range(17, 64);
      else if (cur_len_bytes >= 2) len = $urandom_range(200, 300);
      else len = $urandom_range(17, 255);
      if (with_hold && !hold_done && count > target / 3) begin
        // The receiver holds off while a long message keeps coming.
        hold_go <= 1'b1;
        len = 60;
      end
      send_frame(len);
      count += cur_n + cur_len_bytes + int'(len);
    end
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    rx_byte  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cur_sig       = '0;
    cur_n         = 1;
    cur_len_bytes = 1;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset setting: one zero signature byte, one length byte; a zero length first.
    send_byte(8'h55);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'hFF);

    // Zero signature count reads as one, oversized length count as eight.
    apply_setting(64'h0123_4567_89AB_CDEF, 0, 15);
    send_byte(noise_byte());
    send_frame(64'd1);

    // Length count lowered while the length field is half gathered.
    apply_setting(64'h0123_4567_89AB_CDEF, 1, 2);
    send_byte(8'hEF);
    send_byte(8'h00);
    settle();
    write_reg(sld_pkg::RegLenBytes, 64'd1);
    send_byte(8'h03);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'hFE);

    run_phase({$urandom, $urandom}, 8, 8, IDLE_NONE, 140, 1'b0);
    run_phase('1, 15, 1, IDLE_SEND, 140, 1'b0);
    run_phase({$urandom, $urandom}, 3, 2, IDLE_RECV, 140, 1'b0);
    run_phase('0, 0, 0, IDLE_BOTH, 140, 1'b0);
    run_phase({$urandom, $urandom}, 5, 15, IDLE_NONE, 140, 1'b1);
    run_phase({$urandom, $urandom}, 1, 4, IDLE_SEND, 140, 1'b0);
    run_phase({$urandom, $urandom}, 8, 2, IDLE_BOTH, 140, 1'b0);
    run_phase({$urandom, $urandom}, 2, 3, IDLE_RECV, 140, 1'b0);

    settle();
    repeat (10) @(negedge clk);
    $display("summary: %0d bytes taken in, %0d payload words checked, %0d register settings,",
             bytes_in, words_out, settings);
    $display("summary: idle, sender-gap, receiver-stall and long hold-off phases all run");
    if (err_count == 0 && pending == 0) begin
      $display("signature_length_deframer_tb: clean");
    end else begin
      $display("signature_length_deframer_tb: errors");
    end
    $finish;
  end

endmodule
